[sv/sliding_window_extreme_filter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window extreme filter
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_EXTREME_FILTER_ASSERT_SVH
`define SLIDING_WINDOW_EXTREME_FILTER_ASSERT_SVH

`define SWEF_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define SWEF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define SWEF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/swef_pkg.sv]
// ----------------------------------------------------------------------------
// swef_pkg
// Shared constants, types and pointer helpers of the extreme filter.
// ----------------------------------------------------------------------------
package swef_pkg;

	localparam int WINDOW_MAX   = 64;
	localparam int SAMPLE_WIDTH = 32;
	localparam int POS_W        = 16;
	localparam int CFG_W        = 7;
	localparam int CFG_IDX_W    = 2;
	localparam int PTR_W        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W        = (SAMPLE_WIDTH > POS_W) ? SAMPLE_WIDTH : POS_W;
	localparam int ENTRY_W      = POS_W + SAMPLE_WIDTH;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_EXTREME_MODE = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		CMP_EQ,
		CMP_LE,
		CMP_GT
	} cmp_op_t;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	function automatic ptr_t ptr_inc(input ptr_t p);
		return (p == PTR_W'(WINDOW_MAX - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	function automatic ptr_t ptr_dec(input ptr_t p);
		return (p == '0) ? PTR_W'(WINDOW_MAX - 1) : p - ptr_t'(1);
	endfunction

	function automatic cnt_t eff_window(input logic [CFG_W-1:0] ws);
		if (ws == '0)
			return cnt_t'(1);
		else if (32'(ws) > WINDOW_MAX)
			return CNT_W'(WINDOW_MAX);
		else
			return CNT_W'(ws);
	endfunction

endpackage

[sv/swef_ram.sv]
// ----------------------------------------------------------------------------
// swef_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module swef_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

[sv/swef_cmp.sv]
// ----------------------------------------------------------------------------
// swef_cmp
// Shared compare unit: position match and dominance test.
// ----------------------------------------------------------------------------
module swef_cmp import swef_pkg::*; (
	input  cmp_op_t            op,
	input  logic signed [CMP_W-1:0] a,
	input  logic signed [CMP_W-1:0] b,
	output logic               hit
);

	always_comb begin
		unique case (op)
			CMP_EQ:  hit = (a == b);
			CMP_LE:  hit = (a <= b);
			CMP_GT:  hit = (a > b);
			default: hit = 1'b0;
		endcase
	end

endmodule

[sv/sliding_window_extreme_filter.sv]
// Transactions are serialised by the single compare unit and the one queue RAM
// read port; in_ready is low while one is at work, so no new sample is taken
// until the last one is through.
// Reset clears the queue, counters and output valid; window_size = 1, max mode.
// The queue RAM is not cleared; only the data of occupied entries is ever used.
// ----------------------------------------------------------------------------
// sliding_window_extreme_filter
// Sliding window max/min over a signed stream using a monotonic queue held in
// RAM, walked by a small sequencer around one shared comparator.
// ----------------------------------------------------------------------------
`include "sliding_window_extreme_filter_assert.svh"

module sliding_window_extreme_filter import swef_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_W-1:0]               cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           sequence_start,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] extreme_value
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK_HEAD,
		ST_CHK_BACK,
		ST_APPEND,
		ST_OUT
	} state_t;

	state_t                    state_q;
	logic [CFG_W-1:0]          window_size_q;
	logic                      extreme_mode_q;
	ptr_t                      head_q;
	ptr_t                      tail_q;
	cnt_t                      occ_q;
	cnt_t                      seen_q;
	logic [POS_W-1:0]          pos_q;
	logic signed [SAMPLE_WIDTH-1:0] s_q;
	logic                      use_s_q;
	logic                      out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] extreme_value_q;

	cnt_t                      k;
	logic                      accept;
	logic                      cfg_hit;
	ptr_t                      back;
	cnt_t                      seen_next;
	logic [POS_W-1:0]          expired;
	logic                      slot_free;

	logic                      ram_we;
	logic                      ram_re;
	ptr_t                      ram_raddr;
	logic [ENTRY_W-1:0]        ram_rdata;
	logic [POS_W-1:0]          rd_pos;
	logic signed [SAMPLE_WIDTH-1:0] rd_sample;

	cmp_op_t                   cmp_op;
	logic signed [CMP_W-1:0]   cmp_a;
	logic signed [CMP_W-1:0]   cmp_b;
	logic                      cmp_hit;

	assign k         = eff_window(window_size_q);
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_hit   = cfg_we && (cfg_index == REG_WINDOW_SIZE || cfg_index == REG_EXTREME_MODE);
	assign back      = ptr_dec(tail_q);
	assign seen_next = (seen_q < k) ? seen_q + cnt_t'(1) : seen_q;
	assign expired   = pos_q - POS_W'(k);
	assign slot_free = !out_valid_q || out_ready;
	assign rd_pos    = ram_rdata[ENTRY_W-1 -: POS_W];
	assign rd_sample = ram_rdata[SAMPLE_WIDTH-1:0];
	assign ram_we    = (state_q == ST_APPEND) && (occ_q < CNT_W'(WINDOW_MAX));

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = head_q;
		cmp_op    = CMP_EQ;
		cmp_a     = CMP_W'(rd_pos);
		cmp_b     = CMP_W'(expired);
		unique case (state_q)
			ST_IDLE: begin
				ram_re    = accept;
				ram_raddr = sequence_start ? '0 : head_q;
			end
			ST_CHK_HEAD: begin
				ram_re    = 1'b1;
				ram_raddr = back;
			end
			ST_CHK_BACK: begin
				cmp_op    = extreme_mode_q ? CMP_GT : CMP_LE;
				cmp_a     = CMP_W'(rd_sample);
				cmp_b     = CMP_W'(s_q);
				ram_re    = cmp_hit;
				ram_raddr = ptr_dec(back);
			end
			ST_APPEND: begin
				ram_re    = 1'b1;
				ram_raddr = head_q;
			end
			ST_OUT: begin
				ram_re    = 1'b0;
			end
			default: begin
				ram_re    = 1'b0;
			end
		endcase
	end

	swef_cmp u_cmp (
		.op  (cmp_op),
		.a   (cmp_a),
		.b   (cmp_b),
		.hit (cmp_hit)
	);

	swef_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (WINDOW_MAX)
	) u_queue_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata ({pos_q, s_q}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			window_size_q  <= CFG_W'(1);
			extreme_mode_q <= 1'b0;
			head_q         <= '0;
			tail_q         <= '0;
			occ_q          <= '0;
			seen_q         <= '0;
			pos_q          <= '0;
			use_s_q        <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (state_q == ST_OUT && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_hit) begin
				if (cfg_index == REG_WINDOW_SIZE)
					window_size_q <= cfg_data;
				else
					extreme_mode_q <= cfg_data[0];
				head_q <= '0;
				tail_q <= '0;
				occ_q  <= '0;
				seen_q <= '0;
				pos_q  <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sequence_start) begin
							head_q <= '0;
							tail_q <= '0;
							occ_q  <= '0;
							seen_q <= '0;
							pos_q  <= '0;
						end
						state_q <= (sequence_start || occ_q == '0) ? ST_APPEND : ST_CHK_HEAD;
					end
				end
				ST_CHK_HEAD: begin
					if (cmp_hit) begin
						head_q  <= ptr_inc(head_q);
						occ_q   <= occ_q - cnt_t'(1);
						state_q <= (occ_q == cnt_t'(1)) ? ST_APPEND : ST_CHK_BACK;
					end else begin
						state_q <= ST_CHK_BACK;
					end
				end
				ST_CHK_BACK: begin
					if (cmp_hit) begin
						tail_q  <= back;
						occ_q   <= occ_q - cnt_t'(1);
						state_q <= (occ_q == cnt_t'(1)) ? ST_APPEND : ST_CHK_BACK;
					end else begin
						state_q <= ST_APPEND;
					end
				end
				ST_APPEND: begin
					if (ram_we) begin
						tail_q <= ptr_inc(tail_q);
						occ_q  <= occ_q + cnt_t'(1);
					end
					pos_q   <= pos_q + POS_W'(1);
					seen_q  <= seen_next;
					use_s_q <= (occ_q == '0);
					state_q <= (seen_next >= k) ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			s_q <= sample;
		if (state_q == ST_OUT && slot_free)
			extreme_value_q <= use_s_q ? s_q : rd_sample;
	end

	assign out_valid     = out_valid_q;
	assign extreme_value = extreme_value_q;

	`SWEF_ASSERT_ALWAYS(a_occ_bound, occ_q <= CNT_W'(WINDOW_MAX), "queue occupancy overflow")
	`SWEF_ASSERT_ALWAYS(a_seen_bound, seen_q <= k, "samples seen exceeds window")
	`SWEF_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "ready held after transaction")
	`SWEF_ASSERT_NEXT(a_write_fills, ram_we, occ_q != '0, "queue empty after append")

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: sliding window extreme filter
// Drives signed samples through valid/ready, tracks the window max/min with a
// monotonic candidate queue of its own and checks every result in order.
// Covers directed extremes, spare register indexes, random settings under
// sender/receiver idling and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
	import swef_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
	localparam int SETTLE_CYCLES = 100;
	localparam int STUCK_LIMIT   = 3000;
	localparam int PHASE_ITEMS   = 90;
	localparam int HOLD_CYCLES   = 400;

	typedef enum int {PAT_RANDOM, PAT_NARROW, PAT_RISING, PAT_FALLING} pattern_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [CFG_IDX_W-1:0]           cfg_index;
	logic [CFG_W-1:0]               cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           sequence_start;
	logic                           out_valid;
	logic                           out_ready;
	logic signed [SAMPLE_WIDTH-1:0] extreme_value;

	// candidate queue mirror
	logic signed [SAMPLE_WIDTH-1:0] cand_val[WINDOW_MAX];
	logic [POS_W-1:0]               cand_pos[WINDOW_MAX];
	ptr_t                           cand_head;
	ptr_t                           cand_tail;
	int                             cand_count;
	logic [POS_W-1:0]               seq_pos;
	int                             seq_seen;
	logic [CFG_W-1:0]               cur_window = CFG_W'(1);
	logic                           cur_min_mode = 1'b0;

	logic signed [SAMPLE_WIDTH-1:0] expected_extremes[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;
	int hold_ack       = 0;
	int hold_left      = 0;
	int stuck_cycles   = 0;
	int failures       = 0;
	int samples_sent   = 0;

	sliding_window_extreme_filter i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.sequence_start (sequence_start),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.extreme_value  (extreme_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void restart_sequence();
		cand_head  = '0;
		cand_tail  = '0;
		cand_count = 0;
		seq_pos    = '0;
		seq_seen   = 0;
	endfunction

	function automatic int span();
		if (cur_window == '0)
			return 1;
		if (int'(cur_window) > WINDOW_MAX)
			return WINDOW_MAX;
		return int'(cur_window);
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		case (idx)
			REG_WINDOW_SIZE: begin
				cur_window = data;
				restart_sequence();
			end
			REG_EXTREME_MODE: begin
				cur_min_mode = data[0];
				restart_sequence();
			end
			default: ;
		endcase
	endfunction

	function automatic void track_extreme(input logic signed [SAMPLE_WIDTH-1:0] s,
			input logic st);
		int               k;
		logic [POS_W-1:0] expired;
		ptr_t             back;
		logic             drop;
		k = span();
		if (st)
			restart_sequence();
		expired = seq_pos - POS_W'(k);
		if (cand_count > 0 && cand_pos[cand_head] == expired) begin
			cand_head  = cand_head + ptr_t'(1);
			cand_count = cand_count - 1;
		end
		while (cand_count > 0) begin
			back = cand_tail - ptr_t'(1);
			drop = cur_min_mode ? (cand_val[back] > s) : (cand_val[back] <= s);
			if (!drop)
				break;
			cand_tail  = back;
			cand_count = cand_count - 1;
		end
		if (cand_count < WINDOW_MAX) begin
			cand_pos[cand_tail] = seq_pos;
			cand_val[cand_tail] = s;
			cand_tail  = cand_tail + ptr_t'(1);
			cand_count = cand_count + 1;
		end
		seq_pos = seq_pos + POS_W'(1);
		if (seq_seen < k)
			seq_seen = seq_seen + 1;
		if (seq_seen >= k)
			expected_extremes = {expected_extremes, cand_val[cand_head]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_ack != hold_req) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// handshakes are sampled mid-cycle; they complete at the next rising edge
	always @(negedge clk) begin : monitor
		logic signed [SAMPLE_WIDTH-1:0] want;
		if (arst_n) begin
			if (in_valid && in_ready)
				track_extreme(sample, sequence_start);
			if (out_valid && out_ready) begin
				if (expected_extremes.size() == 0) begin
					$display("%0t: unexpected transaction: expected none, actual %0d",
						$time, extreme_value);
					failures++;
				end else begin
					want = expected_extremes[0];
					expected_extremes.delete(0);
					if (extreme_value !== want) begin
						$display("%0t: extreme_value mismatch: expected %0d, actual %0d",
							$time, want, extreme_value);
						failures++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		apply_register(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic st);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid       <= 1'b1;
		sample         <= s;
		sequence_start <= st;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		samples_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_extremes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] window, input logic min_mode);
		if ($urandom_range(1)) begin
			write_reg(REG_WINDOW_SIZE, window);
			write_reg(REG_EXTREME_MODE, CFG_W'(min_mode));
		end else begin
			write_reg(REG_EXTREME_MODE, CFG_W'(min_mode));
			write_reg(REG_WINDOW_SIZE, window);
		end
	endtask

	function automatic logic signed [SAMPLE_WIDTH-1:0] next_value(input pattern_t pat,
			input logic signed [SAMPLE_WIDTH-1:0] prev);
		case (pat)
			PAT_NARROW:  return SAMPLE_WIDTH'(int'($urandom_range(6)) - 3);
			PAT_RISING:  return prev + SAMPLE_WIDTH'($urandom_range(1000));
			PAT_FALLING: return prev - SAMPLE_WIDTH'($urandom_range(1000));
			default:     return SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	task automatic run_segment(input int n, input bit restarts);
		pattern_t                       pat;
		logic signed [SAMPLE_WIDTH-1:0] v;
		logic                           st;
		v = SAMPLE_WIDTH'($urandom);
		pat = pattern_t'($urandom_range(3));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(15) == 0)
				pat = pattern_t'($urandom_range(3));
			v  = next_value(pat, v);
			st = restarts && ($urandom_range(11) == 0);
			send_sample(v, st);
		end
	endtask

	task automatic test_directed_max();
		write_reg(REG_WINDOW_SIZE, CFG_W'(3));
		write_reg(REG_EXTREME_MODE, CFG_W'(0));
		send_sample(32'sh7fffffff, 1'b1);
		send_sample(32'sh80000000, 1'b0);
		send_sample(32'sh00000000, 1'b0);
		send_sample(-32'sd1, 1'b0);
		send_sample(32'sd1, 1'b0);
		send_sample(32'sd5, 1'b0);
		send_sample(32'sd5, 1'b0);
		send_sample(32'sd5, 1'b0);
		send_sample(32'sh80000000, 1'b1);
		send_sample(32'sh7fffffff, 1'b0);
		send_sample(-32'sd5, 1'b0);
		drain();
	endtask

	task automatic test_directed_min();
		write_reg(REG_WINDOW_SIZE, CFG_W'(0));
		write_reg(REG_EXTREME_MODE, CFG_W'(1));
		send_sample(32'sd3, 1'b0);
		send_sample(32'sh80000000, 1'b0);
		send_sample(32'sh7fffffff, 1'b1);
		drain();
		write_reg(REG_WINDOW_SIZE, CFG_W'(2));
		send_sample(32'sd4, 1'b0);
		send_sample(32'sd4, 1'b0);
		send_sample(32'sd4, 1'b0);
		send_sample(32'sd2, 1'b0);
		send_sample(32'sh7fffffff, 1'b0);
		send_sample(32'sh80000000, 1'b0);
		drain();
	endtask

	// writes to unused indexes must leave the running sequence alone
	task automatic test_spare_index();
		write_reg(REG_WINDOW_SIZE, CFG_W'(4));
		write_reg(REG_EXTREME_MODE, CFG_W'(0));
		send_sample(32'sd9, 1'b0);
		send_sample(-32'sd9, 1'b0);
		send_sample(32'sd2, 1'b0);
		drain();
		write_reg(REG_SPARE_A, CFG_W'($urandom));
		write_reg(REG_SPARE_B, '1);
		send_sample(32'sd1, 1'b0);
		send_sample(32'sd0, 1'b0);
		send_sample(32'sd7, 1'b0);
		drain();
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct);
		int               first;
		int               sel;
		logic [CFG_W-1:0] w;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		first = samples_sent;
		while (samples_sent - first < PHASE_ITEMS) begin
			sel = $urandom_range(9);
			if (sel < 6)
				w = CFG_W'($urandom_range(1, 8));
			else if (sel == 6)
				w = '0;
			else if (sel == 7)
				w = CFG_W'($urandom_range(9, 63));
			else
				w = CFG_W'($urandom_range(64, 127));
			configure(w, 1'($urandom_range(1)));
			run_segment(span() + $urandom_range(4, 30), 1'b1);
			drain();
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		configure(CFG_W'(8), 1'($urandom_range(1)));
		hold_req <= hold_req + 1;
		run_segment(60, 1'b0);
		drain();
	endtask

	initial begin
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= '0;
		cfg_data       <= '0;
		in_valid       <= 1'b0;
		sample         <= '0;
		sequence_start <= 1'b0;
		restart_sequence();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_max();
		test_directed_min();
		test_spare_index();
		test_random_phase(0, 0);
		test_random_phase(64, 0);
		test_random_phase(0, 64);
		test_random_phase(21, 21);
		test_backpressure();

		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
